>>> rtl/core/square_matrix_multiply_macros.svh
// assertion macros shared by the checker
`ifndef SQUARE_MATRIX_MULTIPLY_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication
`define SMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/smm_pkg.sv
package smm_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 35;
    localparam int IDX_W  = 3;
    localparam int SIZE_W = 4;
    localparam int CNT_W  = 7;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_value;
        logic signed [ELEM_W-1:0] b_value;
    } in_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] product_value;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic                     last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT,
        ST_ADV
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LOAD_DONE,
        C_K_LAST,
        C_PIPE_EMPTY,
        C_OUT_FREE,
        C_ELEM_LAST
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  clr;
        logic  issue;
        logic  emit;
        logic  adv;
        cond_t cond;
        step_t jump;
        step_t alt;
    } ucode_t;

    // control store: on cond take jump, else alt
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w = '{in_ready: 1'b0, clr: 1'b0, issue: 1'b0, emit: 1'b0, adv: 1'b0,
              cond: C_ALWAYS, jump: ST_LOAD, alt: ST_LOAD};
        case (s)
            ST_LOAD:
            begin
                w.in_ready = 1'b1;
                w.cond     = C_LOAD_DONE;
                w.jump     = ST_CLEAR;
                w.alt      = ST_LOAD;
            end
            ST_CLEAR:
            begin
                w.clr  = 1'b1;
                w.cond = C_ALWAYS;
                w.jump = ST_RUN;
                w.alt  = ST_RUN;
            end
            ST_RUN:
            begin
                w.issue = 1'b1;
                w.cond  = C_K_LAST;
                w.jump  = ST_DRAIN;
                w.alt   = ST_RUN;
            end
            ST_DRAIN:
            begin
                w.cond = C_PIPE_EMPTY;
                w.jump = ST_EMIT;
                w.alt  = ST_DRAIN;
            end
            ST_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = C_OUT_FREE;
                w.jump = ST_ADV;
                w.alt  = ST_EMIT;
            end
            ST_ADV:
            begin
                w.adv  = 1'b1;
                w.cond = C_ELEM_LAST;
                w.jump = ST_LOAD;
                w.alt  = ST_CLEAR;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.jump = ST_LOAD;
                w.alt  = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/square_matrix_multiply.sv
// Square matrix multiplier, C = A*B for sizes 1 to MAX_DIM (matrix_size written on the cfg
// port; 0 acts as 1, above MAX_DIM acts as MAX_DIM; any write restarts loading). The cfg
// port is ready only while the block is loading, and an offered cfg write holds off the
// input item of that cycle. Items (A[r][c], B[r][c] in Q8.8) are taken one per cycle in
// row-major order into two on-chip stores. After the last of n*n items, one
// multiply-accumulate unit driven by a small microcode program computes each C element
// in the steps clear, n reads, a read/multiply/accumulate drain, emit and advance,
// and emits them row-major as exact Q19.16 values with last_of_run on the final one; no
// item is taken until the whole product has been emitted. The run time is set by the
// single multiply-accumulate unit and its pipeline drain; a stalled output holds the
// sequencer at its emit step.
module square_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  smm_pkg::in_item_t        in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output smm_pkg::out_item_t       out_data
);
    import smm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];

    step_t                    step_reg, step_next;
    logic [SIZE_W-1:0]        size_reg, size_next;
    logic [CNT_W-1:0]         load_count_reg, load_count_next;
    logic [IDX_W-1:0]         i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                     rd_v_reg, mul_v_reg;
    logic signed [ELEM_W-1:0] a_q_reg, b_q_reg;
    logic signed [2*ELEM_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;

    ucode_t                   uc;
    logic [SIZE_W-1:0]        size_m1, cfg_size;
    logic [CNT_W-1:0]         total, load_inc, a_lin, b_lin;
    logic                     in_fire, load_done, k_last, i_last, j_last;
    logic                     out_free, cond_hit;

    assign uc        = ucode_rom(step_reg);
    assign cfg_ready = uc.in_ready;
    assign in_ready  = uc.in_ready && !cfg_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cfg_size  = (cfg_data == '0) ? SIZE_W'(1)
                     : ((cfg_data > MAX_SIZE) ? MAX_SIZE : cfg_data);
    assign size_m1   = size_reg - SIZE_W'(1);
    assign total     = CNT_W'({3'b0, size_reg} * {3'b0, size_reg});
    assign load_inc  = load_count_reg + CNT_W'(1);
    assign in_fire   = in_valid && in_ready;
    assign load_done = load_inc >= total;
    assign k_last    = {1'b0, k_reg} == size_m1;
    assign i_last    = {1'b0, i_reg} == size_m1;
    assign j_last    = {1'b0, j_reg} == size_m1;
    assign out_free  = !out_valid_reg || out_ready;
    assign a_lin     = CNT_W'({4'b0, i_reg} * {3'b0, size_reg}) + CNT_W'(k_reg);
    assign b_lin     = CNT_W'({4'b0, k_reg} * {3'b0, size_reg}) + CNT_W'(j_reg);

    always_comb
    begin
        case (uc.cond)
            C_ALWAYS:     cond_hit = 1'b1;
            C_LOAD_DONE:  cond_hit = in_fire && load_done;
            C_K_LAST:     cond_hit = k_last;
            C_PIPE_EMPTY: cond_hit = !rd_v_reg && !mul_v_reg;
            C_OUT_FREE:   cond_hit = out_free;
            C_ELEM_LAST:  cond_hit = i_last && j_last;
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next       = cond_hit ? uc.jump : uc.alt;
        size_next       = size_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        if (in_fire)
        begin
            load_count_next = load_done ? '0 : load_inc;
            i_next          = '0;
            j_next          = '0;
        end
        if (cfg_valid && cfg_ready)
        begin
            size_next       = cfg_size;
            load_count_next = '0;
        end
        if (uc.clr)
        begin
            k_next   = '0;
            acc_next = '0;
        end
        else if (mul_v_reg)
        begin
            acc_next = acc_reg + PROD_W'(prod_reg);
        end
        if (uc.issue)
        begin
            k_next = k_reg + IDX_W'(1);
        end
        if (uc.emit && out_free)
        begin
            out_valid_next              = 1'b1;
            out_data_next.product_value = acc_reg;
            out_data_next.row_index     = i_reg;
            out_data_next.col_index     = j_reg;
            out_data_next.last_of_run   = i_last && j_last;
        end
        if (uc.adv)
        begin
            if (j_last)
            begin
                j_next = '0;
                i_next = i_last ? '0 : i_reg + IDX_W'(1);
            end
            else
            begin
                j_next = j_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_LOAD;
            size_reg       <= MAX_SIZE;
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rd_v_reg       <= 1'b0;
            mul_v_reg      <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            size_reg       <= size_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            rd_v_reg       <= uc.issue;
            mul_v_reg      <= rd_v_reg;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // element stores, their read registers, the multiply stage and the output data register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_mem[load_count_reg[ADDR_W-1:0]] <= in_data.a_value;
            b_mem[load_count_reg[ADDR_W-1:0]] <= in_data.b_value;
        end
        a_q_reg      <= a_mem[a_lin[ADDR_W-1:0]];
        b_q_reg      <= b_mem[b_lin[ADDR_W-1:0]];
        prod_reg     <= a_q_reg * b_q_reg;
        out_data_reg <= out_data_next;
    end

endmodule

>>> rtl/core/smm_checker.sv
`include "square_matrix_multiply_macros.svh"

module smm_checker #(
    parameter int MAX_DIM = 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input smm_pkg::out_item_t out_data
);
    import smm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DIM - 1);

    `SMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result item dropped while stalled")
    `SMM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "result item changed while stalled")
    `SMM_ASSERT_NOW(a_idx_range, clk, rst_n, out_valid, out_data.row_index <= LAST_IDX && out_data.col_index <= LAST_IDX, "result index beyond matrix")
    `SMM_ASSERT_NOW(a_last_diag, clk, rst_n, out_valid && out_data.last_of_run, out_data.row_index == out_data.col_index, "last item not on the diagonal corner")

endmodule

bind square_matrix_multiply smm_checker #(.MAX_DIM(MAX_DIM)) u_smm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/tb_top.sv
module tb_top;

    import smm_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [SIZE_W-1:0]        size;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     typed;
        logic signed [PROD_W-1:0] want;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [0:25] = '{
        '{ROW_PAIR, 4'd0, 16'sh1111, 16'sh2222, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh7fff, 16'sh8000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh0001, 16'shffff, 1'b0, 35'sd0},
        '{ROW_CFG,  4'd1, 16'sh0000, 16'sh0000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh8000, 1'b1, 35'sd1073741824},
        '{ROW_PAIR, 4'd0, 16'sh7fff, 16'sh8000, 1'b1, -35'sd1073709056},
        '{ROW_PAIR, 4'd0, 16'sh7fff, 16'sh7fff, 1'b1, 35'sd1073676289},
        '{ROW_PAIR, 4'd0, 16'sh0000, 16'sh0000, 1'b1, 35'sd0},
        '{ROW_CFG,  4'd0, 16'sh0000, 16'sh0000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh0100, 16'sh0100, 1'b1, 35'sd65536},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh0001, 1'b1, -35'sd32768},
        '{ROW_CFG,  4'd2, 16'sh0000, 16'sh0000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh8000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh7fff, 16'sh8000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh7fff, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh8000, 1'b0, 35'sd0},
        '{ROW_CFG,  4'd3, 16'sh0000, 16'sh0000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh0100, 16'shff00, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh7fff, 16'sh0080, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh1234, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'shedcc, 16'sh0001, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'shffff, 16'sh8000, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh5555, 16'shaaaa, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh0000, 16'sh7fff, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh3c3c, 16'shc3c3, 1'b0, 35'sd0},
        '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh8000, 1'b0, 35'sd0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;

    // matrix loader state
    logic signed [ELEM_W-1:0] a_mem [0:63];
    logic signed [ELEM_W-1:0] b_mem [0:63];
    int unsigned              load_pos;
    logic [SIZE_W-1:0]        size_reg;

    out_item_t c_elements_q [$];

    int unsigned err_count;
    int unsigned pairs_sent;
    int unsigned runs_done;
    int unsigned c_checked;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req;

    square_matrix_multiply u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned dim_in_use();
        if (size_reg == '0)
            return 1;
        if (size_reg > 4'd8)
            return 8;
        return {28'b0, size_reg};
    endfunction

    function automatic void apply_size(logic [SIZE_W-1:0] v);
        size_reg = v;
        load_pos = 0;
    endfunction

    // store one pair, and on the last pair of a matrix queue every element of C
    function automatic void absorb_pair(logic signed [ELEM_W-1:0] a,
                                        logic signed [ELEM_W-1:0] b,
                                        logic typed, logic signed [PROD_W-1:0] want);
        int unsigned n;
        longint      acc;
        out_item_t   c;
        n = dim_in_use();
        if (load_pos >= n * n)
            load_pos = 0;
        a_mem[load_pos] = a;
        b_mem[load_pos] = b;
        load_pos++;
        if (load_pos < n * n)
            return;
        load_pos = 0;
        runs_done++;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += longint'(a_mem[i * n + k]) * longint'(b_mem[k * n + j]);
                c.product_value = typed ? want : acc[PROD_W-1:0];
                c.row_index     = i[IDX_W-1:0];
                c.col_index     = j[IDX_W-1:0];
                c.last_of_run   = (i == n - 1) && (j == n - 1);
                c_elements_q.push_back(c);
            end
        end
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 16'sh8000;
        if (r < 6)
            return 16'sh7fff;
        if (r == 6)
            return 16'sh0000;
        return ELEM_W'($urandom());
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 4'd0;
        if (r < 68)
            return SIZE_W'($urandom_range(1, 3));
        if (r < 93)
            return SIZE_W'($urandom_range(4, 5));
        return SIZE_W'($urandom_range(6, 7));
    endfunction

    task automatic send_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                             input logic typed, input logic signed [PROD_W-1:0] want);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{a_value: a, b_value: b};
        do
            @(posedge clk);
        while (!in_ready);
        absorb_pair(a, b, typed, want);
        pairs_sent++;
    endtask

    // sender pauses until every queued C element is out and the block is back to loading
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (c_elements_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_size(v);
    endtask

    task automatic random_runs(input int unsigned quota);
        int unsigned sent;
        int unsigned total;
        int unsigned cut;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 99) < 50)
            begin
                wait_drained();
                write_size(pick_size());
            end
            total = dim_in_use() * dim_in_use();
            if (total > 1 && $urandom_range(0, 99) < 15)
            begin
                // partial matrix, then a size write drops it
                cut = $urandom_range(1, total - 1);
                repeat (cut) send_pair(rand_elem(), rand_elem(), 1'b0, '0);
                sent += cut;
                wait_drained();
                write_size(pick_size());
            end
            else
            begin
                repeat (total) send_pair(rand_elem(), rand_elem(), 1'b0, '0);
                sent += total;
            end
        end
    endtask

    // full-size matrix with one row/column pair at each product extreme
    task automatic extreme_run();
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        wait_drained();
        write_size(4'd15);
        for (int p = 0; p < 64; p++)
        begin
            a = rand_elem();
            b = rand_elem();
            if (p / 8 == 0)
                a = 16'sh8000;
            if (p % 8 == 0)
                b = 16'sh8000;
            if (p / 8 == 1)
                a = 16'sh7fff;
            if (p % 8 == 1)
                b = 16'sh8000;
            send_pair(a, b, 1'b0, '0);
        end
    endtask

    // receiver: check accepted C elements, then choose next ready
    initial
    begin
        int unsigned hold_left;
        out_item_t   exp;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                c_checked++;
                if (c_elements_q.size() == 0)
                begin
                    $display("%0t: unexpected C element, expected none, got %p", $time, out_data);
                    err_count++;
                end
                else
                begin
                    exp = c_elements_q.pop_front();
                    if (out_data.product_value !== exp.product_value)
                    begin
                        $display("%0t: product_value expected %0d got %0d", $time,
                                 exp.product_value, out_data.product_value);
                        err_count++;
                    end
                    if (out_data.row_index !== exp.row_index)
                    begin
                        $display("%0t: row_index expected %0d got %0d", $time,
                                 exp.row_index, out_data.row_index);
                        err_count++;
                    end
                    if (out_data.col_index !== exp.col_index)
                    begin
                        $display("%0t: col_index expected %0d got %0d", $time,
                                 exp.col_index, out_data.col_index);
                        err_count++;
                    end
                    if (out_data.last_of_run !== exp.last_of_run)
                    begin
                        $display("%0t: last_of_run expected %0d got %0d", $time,
                                 exp.last_of_run, out_data.last_of_run);
                        err_count++;
                    end
                end
            end
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        err_count     = 0;
        pairs_sent    = 0;
        runs_done     = 0;
        c_checked     = 0;
        hold_req      = 0;
        send_idle_pct = 32;
        recv_idle_pct = 88;
        for (int p = 0; p < 64; p++)
        begin
            a_mem[p] = '0;
            b_mem[p] = '0;
        end
        apply_size(4'd8);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[r])
        begin
            if (DIR_TAB[r].kind == ROW_CFG)
            begin
                wait_drained();
                write_size(DIR_TAB[r].size);
            end
            else
                send_pair(DIR_TAB[r].a, DIR_TAB[r].b, DIR_TAB[r].typed, DIR_TAB[r].want);
        end

        random_runs(10);
        send_idle_pct = 88;
        recv_idle_pct = 32;
        random_runs(10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_runs(10);
        extreme_run();

        // long receiver stall with two matrices offered back to back
        wait_drained();
        write_size(4'd3);
        hold_req = HOLD_CYCLES;
        repeat (18) send_pair(rand_elem(), rand_elem(), 1'b0, '0);

        wait_drained();
        repeat (50) @(posedge clk);
        if (c_elements_q.size() != 0)
        begin
            $display("%0t: %0d C elements never arrived", $time, c_elements_q.size());
            err_count++;
        end
        $display("run covered %0d pairs over %0d matrix products, %0d C elements checked",
                 pairs_sent, runs_done, c_checked);
        $display("sizes 0 to 7 and 15 written, mid-load size writes, long output stall, skewed idling");
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/smm_pkg.sv
rtl/core/square_matrix_multiply.sv
rtl/core/smm_checker.sv
tb/tb_top.sv
